// ===== design/bdsw_pkg.sv =====
`default_nettype none
package bdsw_pkg;

  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 16;
  localparam int CFG_R_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int PIX_W     = 8;
  localparam int ROW_W     = 16;
  localparam int OUT_COL_W = 10;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RADIUS = 2'd2;

  localparam logic [CFG_W_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CFG_H_W-1:0] RST_HEIGHT = 16'd480;
  localparam logic [CFG_R_W-1:0] RST_RADIUS = 3'd1;

  localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
  localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

  // raster facts of one word, worked out when it is taken in
  typedef struct packed {
    logic                 interior;
    logic                 frame_end;
    logic                 col_zero;
    logic [ROW_W-1:0]     out_row;
    logic [OUT_COL_W-1:0] out_col;
  } raster_info_t;

endpackage
`default_nettype wire

// ===== design/bdsw_dist_mem.sv =====
`default_nettype none
module bdsw_dist_mem import bdsw_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int DW    = 4,
  parameter int SAT   = 15
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DW-1:0]            rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DW-1:0]            wr_data,
  output logic                          busy
);

  localparam int AW = $clog2(DEPTH);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  logic          we;
  logic [AW-1:0] wa;
  logic [DW-1:0] wd;

  // the clearing pass owns the write port until it is done
  always_comb begin
    if (clr_busy_r) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = DW'(SAT);
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule
`default_nettype wire

// ===== design/bdsw_raster.sv =====
`default_nettype none
module bdsw_raster import bdsw_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int WW         = ($clog2(MAX_WIDTH + 1) > CFG_W_W) ? $clog2(MAX_WIDTH + 1) : CFG_W_W,
  parameter int RW         = $clog2(MAX_RADIUS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               advance,
  input  wire logic [WW-1:0]      eff_w,
  input  wire logic [CFG_H_W-1:0] eff_h,
  input  wire logic [RW-1:0]      rad,
  input  wire logic [RW:0]        span,
  output logic      [CW-1:0]      addr,
  output raster_info_t            info
);

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;

  logic [ROW_W:0]             r_a, r_inc;
  logic [CW-1:0]              c_a;
  logic [ROW_W-1:0]           r0;
  logic [CW-1:0]              c0;
  logic [WW-1:0]              c_inc;
  logic [OUT_COL_W+CW-1:0]    col_tmp;
  logic                       interior;

  always_comb begin
    // a size change can leave the position outside the frame: wrap it first
    r_a = {1'b0, row_r};
    c_a = col_r;
    if (WW'(col_r) >= eff_w) begin
      c_a = '0;
      r_a = {1'b0, row_r} + (ROW_W + 1)'(1);
    end
    if (r_a >= {1'b0, eff_h}) begin
      r_a = '0;
      c_a = '0;
    end
    r0 = r_a[ROW_W-1:0];
    c0 = c_a;

    c_inc   = WW'(c0) + WW'(1);
    r_inc   = {1'b0, r0} + (ROW_W + 1)'(1);
    col_nxt = CW'(c_inc);
    row_nxt = r0;
    if (c_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (r_inc >= {1'b0, eff_h}) ? '0 : r_inc[ROW_W-1:0];
    end

    interior = (r0 >= ROW_W'(span)) && (WW'(c0) >= WW'(span));
    col_tmp  = {{OUT_COL_W{1'b0}}, c0 - CW'(rad)};

    info.interior  = interior;
    info.frame_end = (r0 == eff_h - CFG_H_W'(1)) && (WW'(c0) == eff_w - WW'(1));
    info.col_zero  = (c0 == '0);
    info.out_row   = interior ? (r0 - ROW_W'(rad)) : '0;
    info.out_col   = interior ? col_tmp[OUT_COL_W-1:0] : '0;
    addr           = c0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (advance) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/binary_dilation_square_window.sv =====
`default_nettype none
// Pipeline: a taken pixel passes the stage 1 and then the output registers.
// Throughput: one pixel per cycle unless in_stall is high (clearing, or stage 1
// held by out_stall); the column distance memory is read as a pixel is taken
// and written back as it leaves stage 1, with a bypass for a repeated column.
// Reset: clears MAX_WIDTH (1024 by default) entries; sets 640 x 480, radius 1.
module binary_dilation_square_window import bdsw_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIX_W-1:0]      in_pixel_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_out_valid,
  output logic      [PIX_W-1:0]      out_pixel,
  output logic      [ROW_W-1:0]      out_row,
  output logic      [OUT_COL_W-1:0]  out_col,
  output logic                       out_frame_end
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > CFG_W_W) ? $clog2(MAX_WIDTH + 1) : CFG_W_W;
  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int SAT = 2 * MAX_RADIUS + 1;
  localparam int DW  = $clog2(SAT + 1);

  logic [CFG_W_W-1:0] width_r;
  logic [CFG_H_W-1:0] height_r;
  logic [CFG_R_W-1:0] radius_r;

  logic [WW-1:0]      eff_w;
  logic [CFG_H_W-1:0] eff_h;
  logic [RW-1:0]      rad;
  logic [RW:0]        span;

  logic               accept, s1_adv, clr_busy;
  logic [CW-1:0]      rd_addr;
  raster_info_t       info;
  logic [DW-1:0]      rd_data;

  logic               s1_v_r;
  logic               s1_set_r;
  logic [CW-1:0]      s1_addr_r;
  raster_info_t       s1_info_r;
  logic               fwd_hit_r;
  logic [DW-1:0]      fwd_d_r;
  logic [DW-1:0]      hd_r, hd_nxt;

  logic [DW-1:0]      d_in, d_nxt, hd_base;
  logic               hit;

  logic               out_v_r;
  logic               out_iv_r;
  logic [PIX_W-1:0]   out_pix_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic               out_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      radius_r <= RST_RADIUS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_data[CFG_W_W-1:0];
        CFG_IDX_HEIGHT: height_r <= cfg_data[CFG_H_W-1:0];
        CFG_IDX_RADIUS: radius_r <= cfg_data[CFG_R_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (WW'(width_r) > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    eff_h = (height_r == '0) ? CFG_H_W'(1) : height_r;
    rad   = (int'(radius_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_r);
    span  = {rad, 1'b0};
  end

  assign s1_adv   = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = clr_busy || (s1_v_r && !s1_adv);
  assign accept   = in_valid && !in_stall;

  bdsw_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS),
    .CW         (CW),
    .WW         (WW),
    .RW         (RW)
  ) u_raster (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .eff_w   (eff_w),
    .eff_h   (eff_h),
    .rad     (rad),
    .span    (span),
    .addr    (rd_addr),
    .info    (info)
  );

  bdsw_dist_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (DW),
    .SAT   (SAT)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr_r),
    .wr_data (d_nxt),
    .busy    (clr_busy)
  );

  // read-modify-write of the column distance and the running row distance
  always_comb begin
    d_in = fwd_hit_r ? fwd_d_r : rd_data;
    if (s1_set_r) begin
      d_nxt = '0;
    end else if (d_in < DW'(SAT)) begin
      d_nxt = d_in + DW'(1);
    end else begin
      d_nxt = d_in;
    end
    hd_base = s1_info_r.col_zero ? DW'(SAT) : hd_r;
    if (d_nxt <= DW'(span)) begin
      hd_nxt = '0;
    end else if (hd_base < DW'(SAT)) begin
      hd_nxt = hd_base + DW'(1);
    end else begin
      hd_nxt = hd_base;
    end
    hit = (hd_nxt <= DW'(span));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
      hd_r      <= DW'(SAT);
    end else begin
      if (accept) begin
        s1_v_r    <= 1'b1;
        // memory reads the old value when the same column is written this edge
        fwd_hit_r <= s1_adv && (s1_addr_r == rd_addr);
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        hd_r <= hd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_set_r  <= (in_pixel_value != '0);
      s1_addr_r <= rd_addr;
      s1_info_r <= info;
      fwd_d_r   <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_iv_r  <= s1_info_r.interior;
      out_pix_r <= (s1_info_r.interior && hit) ? PIX_ON : PIX_OFF;
      out_row_r <= s1_info_r.out_row;
      out_col_r <= s1_info_r.out_col;
      out_fe_r  <= s1_info_r.frame_end;
    end
  end

  assign out_valid     = out_v_r;
  assign out_out_valid = out_iv_r;
  assign out_pixel     = out_pix_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_frame_end = out_fe_r;

endmodule
`default_nettype wire
